// ----- sv/scs_pkg.sv -----
// Shared types, codes and helper functions for the comment stripper.
`timescale 1ns / 1ps
`default_nettype none
package scs_pkg;

    // input actions
    localparam logic [1:0] ACT_CHAR = 2'd0;
    localparam logic [1:0] ACT_EOL  = 2'd1;
    localparam logic [1:0] ACT_EOT  = 2'd2;
    localparam logic [1:0] ACT_RSVD = 2'd3;

    // result kinds
    localparam logic [1:0] K_CHAR = 2'd0;
    localparam logic [1:0] K_FIN  = 2'd1;
    localparam logic [1:0] K_BAD  = 2'd2;
    localparam logic [1:0] K_LONG = 2'd3;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // configuration register indexes
    localparam logic REG_LINE_LIMIT = 1'b0;
    localparam logic REG_OUT_LIMIT  = 1'b1;

    localparam logic [15:0] LINE_LIMIT_RST = 16'd1024;
    localparam logic [15:0] OUT_LIMIT_RST  = 16'd65533;

    // result queue
    localparam int RQ_DEPTH = 8;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);
    localparam int RQ_CW    = $clog2(RQ_DEPTH + 1) + 1;
    localparam int MAX_RES  = 3;

    typedef enum logic [3:0] {
        M_IDLE  = 4'b0001,
        M_NORM  = 4'b0010,
        M_BLOCK = 4'b0100,
        M_LINE  = 4'b1000
    } t_mode;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  ch;
        logic [15:0] line;
        logic [15:0] pos;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [1:0]            n;
        t_res [MAX_RES-1:0]    res;
    } t_push;

    function automatic t_res mk_res(input logic [1:0] kind, input logic [7:0] ch,
                                    input logic [15:0] line, input logic [15:0] pos);
        t_res r;
        r.kind = kind;
        r.ch   = ch;
        r.line = line;
        r.pos  = pos;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic logic legal(input logic [7:0] c);
        logic ok;
        ok = 1'b0;
        if (c >= 8'h30 && c <= 8'h39) ok = 1'b1;
        if (c >= 8'h41 && c <= 8'h5A) ok = 1'b1;
        if (c >= 8'h61 && c <= 8'h7A) ok = 1'b1;
        case (c)
            8'h20, 8'h28, 8'h29, 8'h2B, 8'h2D, 8'h2A, 8'h3D, 8'h7B, 8'h7D,
            8'h5B, 8'h5D, 8'h2F, 8'h5F, 8'h3B, 8'h3A, 8'h2C, 8'h2E, 8'h3E,
            8'h3C, 8'h26, 8'h5E, 8'h7E, 8'h23, 8'h7C, 8'h21, 8'h25, 8'h3F,
            8'h22, 8'h40, 8'h24, 8'h27, 8'h5C, 8'h0A, 8'h0D: ok = 1'b1;
            default: ;
        endcase
        return ok;
    endfunction

endpackage
`default_nettype wire

// ----- sv/scs_step.sv -----
// Input register, scanner state and the per-word step logic.
`timescale 1ns / 1ps
`default_nettype none
module scs_step (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_tvalid,
    output logic                           o_tready,
    input  wire logic [7:0]                i_char,
    input  wire logic [1:0]                i_action,
    input  wire logic [15:0]               i_line_limit,
    input  wire logic [15:0]               i_output_limit,
    input  wire logic [scs_pkg::RQ_CW-1:0] i_q_count,
    output scs_pkg::t_push                 o_push
);
    import scs_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_char;
    logic [1:0]  r_in_action;

    t_mode       r_mode, n_mode;
    logic        r_slash_held, n_slash_held;
    logic        r_star_seen, n_star_seen;
    logic        r_space_written, n_space_written;
    logic [15:0] r_line_count, n_line_count;
    logic [15:0] r_out_pos, n_out_pos;

    t_push       push;
    logic [RQ_CW-1:0] fill;

    // room for the word in flight plus one more word of worst-case results
    assign fill     = i_q_count + RQ_CW'(push.n);
    assign o_tready = (fill <= RQ_CW'(RQ_DEPTH - MAX_RES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_tvalid && o_tready;
        end
        if (i_tvalid && o_tready) begin
            r_in_char   <= i_char;
            r_in_action <= i_action;
        end
    end

    always_comb begin
        t_mode       m;
        logic        sh, ss, sw, alive, skip, fl, do_put;
        logic [15:0] lc, op;
        logic [16:0] nl;
        logic [7:0]  pc;
        logic [1:0]  cnt;
        t_res [MAX_RES-1:0] res;

        m = r_mode; sh = r_slash_held; ss = r_star_seen; sw = r_space_written;
        lc = r_line_count; op = r_out_pos;
        alive = 1'b1; skip = 1'b0; fl = 1'b0; do_put = 1'b0;
        pc = CH_SPACE; nl = '0; cnt = '0; res = '0;

        if (r_in_valid && r_in_action != ACT_RSVD) begin
            if (m == M_IDLE) begin
                sh = 1'b0; ss = 1'b0; sw = 1'b0;
                lc = '0; op = 16'd1; m = M_NORM;
                res[cnt] = mk_res(K_CHAR, CH_SPACE, 16'd0, 16'd0);
                cnt = cnt + 2'd1;
            end

            // held slash: either opens a comment or goes out as itself
            if (m == M_NORM && sh) begin
                if (r_in_action != ACT_CHAR) begin
                    fl = 1'b1;
                end else if (r_in_char == CH_SLASH) begin
                    sh = 1'b0; m = M_LINE; skip = 1'b1;
                end else if (r_in_char == CH_STAR) begin
                    sh = 1'b0; m = M_BLOCK; ss = 1'b1; skip = 1'b1;
                end else begin
                    fl = 1'b1;
                end
            end
            if (fl) begin
                sh = 1'b0; sw = 1'b0;
                res[cnt] = mk_res(K_CHAR, CH_SLASH, lc, op);
                cnt = cnt + 2'd1;
                op = op + 16'd1;
                if (op >= i_output_limit) begin
                    res[cnt] = mk_res(K_LONG, 8'h00, lc, op);
                    cnt = cnt + 2'd1;
                    m = M_IDLE; sh = 1'b0; ss = 1'b0; sw = 1'b0;
                    alive = 1'b0;
                end
            end

            if (alive && !skip) begin
                case (r_in_action)
                    ACT_EOT: begin
                        res[cnt] = mk_res(K_FIN, 8'h00, lc, op);
                        cnt = cnt + 2'd1;
                        m = M_IDLE; sh = 1'b0; ss = 1'b0; sw = 1'b0;
                    end
                    ACT_EOL: begin
                        nl = {1'b0, lc} + 17'd1;
                        lc = nl[15:0];
                        if (nl >= {1'b0, i_line_limit}) begin
                            res[cnt] = mk_res(K_FIN, 8'h00, lc, op);
                            cnt = cnt + 2'd1;
                            m = M_IDLE; sh = 1'b0; ss = 1'b0; sw = 1'b0;
                        end else if (m == M_BLOCK) begin
                            ss = 1'b0;
                        end else if (m == M_LINE) begin
                            m = M_NORM;   // line comment eats its line end
                        end else if (!sw) begin
                            sw = 1'b1; do_put = 1'b1; pc = CH_SPACE;
                        end
                    end
                    ACT_CHAR: begin
                        if (m == M_BLOCK) begin
                            if (ss && r_in_char == CH_SLASH) begin
                                m = M_NORM; ss = 1'b0;
                            end else begin
                                ss = (r_in_char == CH_STAR);
                            end
                        end else if (m == M_LINE) begin
                            ss = ss;
                        end else if (r_in_char == CH_SLASH) begin
                            sh = 1'b1;
                        end else if (!legal(r_in_char)) begin
                            res[cnt] = mk_res(K_BAD, r_in_char, lc, op);
                            cnt = cnt + 2'd1;
                            m = M_IDLE; sh = 1'b0; ss = 1'b0; sw = 1'b0;
                        end else if (r_in_char == CH_SPACE) begin
                            if (!sw) begin
                                sw = 1'b1; do_put = 1'b1; pc = r_in_char;
                            end
                        end else begin
                            sw = 1'b0; do_put = 1'b1; pc = r_in_char;
                        end
                    end
                    default: ;
                endcase
            end

            if (do_put) begin
                res[cnt] = mk_res(K_CHAR, pc, lc, op);
                cnt = cnt + 2'd1;
                op = op + 16'd1;
                if (op >= i_output_limit) begin
                    res[cnt] = mk_res(K_LONG, 8'h00, lc, op);
                    cnt = cnt + 2'd1;
                    m = M_IDLE; sh = 1'b0; ss = 1'b0; sw = 1'b0;
                end
            end

            if (cnt != 2'd0) res[cnt - 2'd1].last = 1'b1;
        end

        n_mode = m; n_slash_held = sh; n_star_seen = ss; n_space_written = sw;
        n_line_count = lc; n_out_pos = op;
        push.n   = cnt;
        push.res = res;
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= M_IDLE;
            r_slash_held    <= 1'b0;
            r_star_seen     <= 1'b0;
            r_space_written <= 1'b0;
            r_line_count    <= '0;
            r_out_pos       <= 16'd1;
        end else begin
            r_mode          <= n_mode;
            r_slash_held    <= n_slash_held;
            r_star_seen     <= n_star_seen;
            r_space_written <= n_space_written;
            r_line_count    <= n_line_count;
            r_out_pos       <= n_out_pos;
        end
    end

`ifndef ASSERT_OFF
    a_slash_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slash_held |-> r_mode == M_NORM)
        else $error("slash held outside normal text");
    a_star_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_star_seen |-> r_mode == M_BLOCK)
        else $error("star flag outside block comment");
    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |-> ({1'b0, i_q_count} + 5'(push.n)) <= 5'(RQ_DEPTH))
        else $error("result queue would overflow");
    a_idle_no_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == M_IDLE |-> !r_slash_held && !r_star_seen && !r_space_written)
        else $error("flags left set after stop");
`endif

endmodule
`default_nettype wire

// ----- sv/scs_rq.sv -----
// Result queue: takes up to three results a cycle, hands out one word a cycle while the receiver is ready.
`timescale 1ns / 1ps
`default_nettype none
module scs_rq (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire scs_pkg::t_push            i_push,
    output logic [scs_pkg::RQ_CW-1:0]      o_count,
    output logic                           o_tvalid,
    input  wire logic                      i_tready,
    output scs_pkg::t_res                  o_res
);
    import scs_pkg::*;

    t_res             r_mem [RQ_DEPTH];
    logic [RQ_AW-1:0] r_wptr, r_rptr;
    logic [RQ_CW-1:0] r_count, n_count;
    logic             pop;

    assign o_tvalid = (r_count != '0);
    assign pop      = o_tvalid && i_tready;
    assign o_res    = r_mem[r_rptr];
    assign o_count  = r_count;
    assign n_count  = r_count + RQ_CW'(i_push.n) - RQ_CW'(pop);

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (2'(k) < i_push.n) r_mem[r_wptr + RQ_AW'(k)] <= i_push.res[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + RQ_AW'(i_push.n);
            r_rptr  <= r_rptr + RQ_AW'(pop);
            r_count <= n_count;
        end
    end

`ifndef ASSERT_OFF
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= RQ_CW'(RQ_DEPTH))
        else $error("queue count past depth");
    a_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        RQ_AW'(r_wptr - r_rptr) == r_count[RQ_AW-1:0])
        else $error("queue pointers disagree with count");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_count == $past(r_count) + RQ_CW'($past(i_push.n)) - RQ_CW'($past(pop)))
        else $error("queue count miscounted");
`endif

endmodule
`default_nettype wire

// ----- sv/source_comment_strip_space_collapse_core.sv -----
// Top level: comment stripper / space collapser with config registers.
//
//  group   dir  payload                                    accepted when
//  s_*     in   tdata[7:0] char_code; tuser[1:0] action    i_s_tvalid & o_s_tready
//  m_*     out  tdata char/line/position; tuser kind; tlast  o_m_tvalid & i_m_tready
//  apb     in   line_limit @0x0, output_limit @0x4         psel & penable & pwrite
//
// Each word is registered, stepped in the next cycle, and its zero to three results
// are written into an eight-entry result queue, from which the receiver takes them.
// A word is taken every cycle as long as the queue has room; the queue hands out one
// result a cycle while the receiver is ready, so the sustained rate is one word a
// cycle or one result a cycle, whichever is slower.
// Reset is synchronous, active low, and clears scanner state and the queue.
// Back-pressure on m_* fills the queue and then drops o_s_tready.
`timescale 1ns / 1ps
`default_nettype none
module source_comment_strip_space_collapse_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] char_code
    input  wire logic [1:0]  i_s_tuser,   // [1:0] action
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [39:0]      o_m_tdata,   // [7:0] char_code_res, [23:8] line, [39:24] position
    output logic [1:0]       o_m_tuser,   // [1:0] kind
    output logic             o_m_tlast,   // last result of the word
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import scs_pkg::*;

    logic [15:0]      r_line_limit;
    logic [15:0]      r_output_limit;
    logic [RQ_CW-1:0] q_count;
    t_push            push;
    t_res             res;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign prdata = {16'h0000, (paddr[2] == REG_OUT_LIMIT) ? r_output_limit : r_line_limit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_limit   <= LINE_LIMIT_RST;
            r_output_limit <= OUT_LIMIT_RST;
        end else if (wr_en) begin
            case (paddr[2])
                REG_LINE_LIMIT: r_line_limit   <= pwdata[15:0];
                REG_OUT_LIMIT:  r_output_limit <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    scs_step u_step (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tvalid       (i_s_tvalid),
        .o_tready       (o_s_tready),
        .i_char         (i_s_tdata),
        .i_action       (i_s_tuser),
        .i_line_limit   (r_line_limit),
        .i_output_limit (r_output_limit),
        .i_q_count      (q_count),
        .o_push         (push)
    );

    scs_rq u_rq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_count  (q_count),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_res    (res)
    );

    assign o_m_tdata = {res.pos, res.line, res.ch};
    assign o_m_tuser = res.kind;
    assign o_m_tlast = res.last;

endmodule
`default_nettype wire

// ----- verif/source_comment_strip_space_collapse_checker.sv -----
// Checker for the comment stripper: predicts every result word and compares it.
`timescale 1ns / 1ps
module source_comment_strip_space_collapse_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] char_code
    input  wire logic [1:0]  i_s_tuser,   // [1:0] action
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [39:0] i_m_tdata,   // [7:0] char_code_res, [23:8] line, [39:24] position
    input  wire logic [1:0]  i_m_tuser,   // [1:0] kind
    input  wire logic        i_m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               o_fail_count,
    output int               o_pending
);
    import scs_pkg::*;

    t_mode       scan_mode;
    logic        slash_pending;
    logic        star_last;
    logic        space_out;
    logic [15:0] cur_line;
    logic [15:0] wr_pos;
    logic [15:0] line_limit;
    logic [15:0] out_limit;

    t_res        step_res [0:MAX_RES-1];
    int          step_n;
    t_res        expected_q [$];
    int          fail_count;

    assign o_fail_count = fail_count;

    function automatic logic is_source_char(input logic [7:0] c);
        if (c >= "0" && c <= "9") return 1'b1;
        if (c >= "A" && c <= "Z") return 1'b1;
        if (c >= "a" && c <= "z") return 1'b1;
        case (c)
            CH_SPACE, CH_STAR, CH_SLASH, "(", ")", "+", "-", "=", "{", "}", "[", "]",
            "_", ";", ":", ",", ".", ">", "<", "&", "^", "~", "#", "|", "!", "%",
            "?", "\"", "@", "$", "'", "\\", 8'd10, 8'd13: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void note(input logic [1:0] kind, input logic [7:0] c,
                                 input logic [15:0] ln, input logic [15:0] pos);
        step_res[step_n] = '{kind: kind, ch: c, line: ln, pos: pos, last: 1'b0};
        step_n++;
    endfunction

    function automatic void stop_text();
        scan_mode     = M_IDLE;
        slash_pending = 1'b0;
        star_last     = 1'b0;
        space_out     = 1'b0;
    endfunction

    function automatic void close_text();
        note(K_FIN, 8'd0, cur_line, wr_pos);
        stop_text();
    endfunction

    // 0 when the output limit was hit and the text stopped
    function automatic logic write_char(input logic [7:0] c);
        note(K_CHAR, c, cur_line, wr_pos);
        wr_pos = wr_pos + 16'd1;
        if (wr_pos >= out_limit) begin
            note(K_LONG, 8'd0, cur_line, wr_pos);
            stop_text();
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic release_slash();
        slash_pending = 1'b0;
        space_out     = 1'b0;
        return write_char(CH_SLASH);
    endfunction

    function automatic void scan_char(input logic [7:0] c);
        if (scan_mode == M_BLOCK) begin
            if (star_last && c == CH_SLASH) begin
                scan_mode = M_NORM;
                star_last = 1'b0;
            end else begin
                star_last = (c == CH_STAR);
            end
            return;
        end
        if (scan_mode == M_LINE) return;
        if (slash_pending) begin
            if (c == CH_SLASH) begin
                slash_pending = 1'b0;
                scan_mode     = M_LINE;
                return;
            end
            // the opening star also counts as a closing one
            if (c == CH_STAR) begin
                slash_pending = 1'b0;
                scan_mode     = M_BLOCK;
                star_last     = 1'b1;
                return;
            end
            if (!release_slash()) return;
        end
        if (c == CH_SLASH) begin
            slash_pending = 1'b1;
            return;
        end
        if (!is_source_char(c)) begin
            note(K_BAD, c, cur_line, wr_pos);
            stop_text();
            return;
        end
        if (c == CH_SPACE) begin
            if (space_out) return;
            space_out = 1'b1;
        end else begin
            space_out = 1'b0;
        end
        void'(write_char(c));
    endfunction

    function automatic void scan_line_end();
        logic [16:0] n;
        if (scan_mode == M_NORM && slash_pending) begin
            if (!release_slash()) return;
        end
        n        = {1'b0, cur_line} + 17'd1;
        cur_line = n[15:0];
        if (n >= {1'b0, line_limit}) begin
            close_text();
            return;
        end
        if (scan_mode == M_BLOCK) begin
            star_last = 1'b0;
        end else if (scan_mode == M_LINE) begin
            scan_mode = M_NORM;   // line comment eats its line end, no space
        end else if (!space_out) begin
            space_out = 1'b1;
            void'(write_char(CH_SPACE));
        end
    endfunction

    function automatic void scan_word(input logic [1:0] act, input logic [7:0] c);
        t_res r;
        step_n = 0;
        if (act == ACT_RSVD) return;
        if (scan_mode == M_IDLE) begin
            stop_text();
            cur_line  = 16'd0;
            wr_pos    = 16'd1;
            scan_mode = M_NORM;
            note(K_CHAR, CH_SPACE, 16'd0, 16'd0);
        end
        if (act == ACT_EOT) begin
            if (scan_mode == M_NORM && slash_pending) begin
                if (release_slash()) close_text();
            end else begin
                close_text();
            end
        end else if (act == ACT_EOL) begin
            scan_line_end();
        end else begin
            scan_char(c);
        end
        for (int i = 0; i < step_n; i++) begin
            r      = step_res[i];
            r.last = (i == step_n - 1);
            expected_q.push_back(r);
        end
    endfunction

    task automatic report(input string what, input logic [39:0] got, input logic [39:0] want);
        $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    task automatic check_result();
        t_res want;
        if (expected_q.size() == 0) begin
            report("word with none expected", i_m_tdata, 40'd0);
            return;
        end
        want = expected_q.pop_front();
        if (i_m_tuser != want.kind)
            report("kind", 40'(i_m_tuser), 40'(want.kind));
        if (i_m_tdata[7:0] != want.ch)
            report("char", 40'(i_m_tdata[7:0]), 40'(want.ch));
        if (i_m_tdata[23:8] != want.line)
            report("line", 40'(i_m_tdata[23:8]), 40'(want.line));
        if (i_m_tdata[39:24] != want.pos)
            report("position", 40'(i_m_tdata[39:24]), 40'(want.pos));
        if (i_m_tlast != want.last)
            report("last", 40'(i_m_tlast), 40'(want.last));
    endtask

    initial fail_count = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stop_text();
            cur_line   = 16'd0;
            wr_pos     = 16'd1;
            line_limit = LINE_LIMIT_RST;
            out_limit  = OUT_LIMIT_RST;
            expected_q.delete();
            o_pending <= 0;
        end else begin
            if (i_m_tvalid && i_m_tready) check_result();
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_OUT_LIMIT) out_limit = pwdata[15:0];
                else                           line_limit = pwdata[15:0];
            end
            if (i_s_tvalid && i_s_tready) scan_word(i_s_tuser, i_s_tdata);
            o_pending <= expected_q.size();
        end
    end

endmodule

// ----- verif/source_comment_strip_space_collapse_core_tb.sv -----
// Testbench top: clock, reset, stimulus and verdict for the comment stripper.
`timescale 1ns / 1ps
module source_comment_strip_space_collapse_core_tb;
    import scs_pkg::*;

    localparam int          LIMIT_CYCLES  = 200000;
    localparam int          SETTLE_CYCLES = 12;
    localparam int          HOLD_CYCLES   = 80;
    localparam logic [2:0]  ADDR_LINE_LIMIT = {REG_LINE_LIMIT, 2'b00};
    localparam logic [2:0]  ADDR_OUT_LIMIT  = {REG_OUT_LIMIT, 2'b00};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;
    logic [1:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [39:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        o_m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    int          words_sent;
    int          cycle_cnt;
    bit          tx_calm;
    bit          rx_calm;
    bit          hold_req;

    source_comment_strip_space_collapse_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    source_comment_strip_space_collapse_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_m_tlast    (o_m_tlast),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // receiver: random stall before each word, plus one long hold on request
    initial begin
        int stall;
        i_m_tready <= 1'b0;
        rx_calm = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = rx_calm ? 0 : $urandom_range(0, 4);
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
        end
    end

    task automatic send_word(input logic [1:0] act, input logic [7:0] c);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= act;
        i_s_tdata  <= c;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (act != ACT_RSVD) words_sent++;
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
    endtask

    task automatic set_limits(input logic [15:0] lines, input logic [15:0] outs);
        apb_write(ADDR_LINE_LIMIT, lines);
        apb_write(ADDR_OUT_LIMIT, outs);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [7:0] random_source_char();
        string punct;
        int    k;
        punct = "()+-=*{}[]_;:,.><&^~#|!%?\"@$'\\";
        k = $urandom_range(0, 9);
        if (k < 4) return "a" + 8'($urandom_range(0, 25));
        if (k < 5) return "A" + 8'($urandom_range(0, 25));
        if (k < 7) return "0" + 8'($urandom_range(0, 9));
        if (k < 9) return punct[$urandom_range(0, punct.len() - 1)];
        return $urandom_range(0, 1) ? 8'd10 : 8'd13;
    endfunction

    // one text of source: mostly legal content, comment openers and line ends;
    // noisy texts mix in any action and any byte and may lack the end mark
    task automatic send_text(input int len, input bit noisy, input bit burst);
        int pick;
        tx_calm = burst || ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            if (noisy && pick < 30)
                send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            else if (pick < 45) send_word(ACT_CHAR, random_source_char());
            else if (pick < 58) send_word(ACT_CHAR, CH_SPACE);
            else if (pick < 68) send_word(ACT_CHAR, CH_SLASH);
            else if (pick < 76) send_word(ACT_CHAR, CH_STAR);
            else if (pick < 88) send_word(ACT_EOL, 8'($urandom_range(0, 255)));
            else if (pick < 90) send_word(ACT_CHAR, 8'($urandom_range(0, 255)));
            else send_word(ACT_CHAR, random_source_char());
        end
        if (!noisy || $urandom_range(0, 1) == 1)
            send_word(ACT_EOT, 8'($urandom_range(0, 255)));
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= 8'd0;
        i_s_tuser  <= ACT_CHAR;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= ADDR_LINE_LIMIT;
        pwdata     <= 32'd0;
        words_sent = 0;
        tx_calm    = 1'b0;
        hold_req   = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset limits
        send_word(ACT_CHAR, "a");             // leading space comes first
        send_word(ACT_CHAR, CH_SPACE);
        send_word(ACT_CHAR, CH_SPACE);        // collapsed
        send_word(ACT_CHAR, CH_SLASH);        // line comment
        send_word(ACT_CHAR, CH_SLASH);
        send_word(ACT_CHAR, 8'hFF);           // not checked inside a comment
        send_word(ACT_EOL, 8'h00);            // swallowed, no space
        send_word(ACT_CHAR, CH_SLASH);        // slash-star-slash is a whole comment
        send_word(ACT_CHAR, CH_STAR);
        send_word(ACT_CHAR, CH_SLASH);
        send_word(ACT_CHAR, CH_SLASH);        // held slash goes out before the line end
        send_word(ACT_EOL, 8'hFF);
        send_word(ACT_CHAR, CH_SLASH);        // block comment over a line end
        send_word(ACT_CHAR, CH_STAR);
        send_word(ACT_CHAR, CH_STAR);
        send_word(ACT_EOL, 8'h00);            // line end forgets the star
        send_word(ACT_CHAR, CH_SLASH);
        send_word(ACT_CHAR, CH_STAR);
        send_word(ACT_CHAR, CH_SLASH);
        send_word(ACT_RSVD, 8'h5A);           // ignored
        send_word(ACT_CHAR, CH_SLASH);
        send_word(ACT_EOT, 8'h00);            // held slash, then finished
        send_word(ACT_CHAR, 8'hFF);           // new text, bad byte at once
        send_word(ACT_CHAR, 8'h00);
        send_word(ACT_CHAR, CH_SLASH);
        send_word(ACT_CHAR, CH_STAR);
        send_word(ACT_EOT, 8'h00);            // open comment dropped
        wait_drained();

        // tight limits: finish on lines, too-long on output
        set_limits(16'd3, 16'd20);
        while (words_sent < 120) send_text($urandom_range(4, 24), 1'b0, 1'b0);
        // receiver holds off while the sender keeps offering words
        hold_req = 1'b1;
        send_text(30, 1'b0, 1'b1);
        wait_drained();

        set_limits(16'hFFFF, 16'hFFFF);
        while (words_sent < 210)
            send_text($urandom_range(8, 30), $urandom_range(0, 2) == 0, 1'b0);
        wait_drained();

        set_limits(16'd1, 16'd2);
        repeat (4) send_text($urandom_range(1, 4), 1'b0, 1'b0);
        wait_drained();

        // line limit zero and output limit below two
        set_limits(16'd0, 16'd1);
        send_word(ACT_EOL, 8'h00);
        send_word(ACT_CHAR, "q");
        send_word(ACT_CHAR, CH_SLASH);
        send_word(ACT_EOT, 8'h00);
        repeat (2) send_text($urandom_range(1, 3), 1'b0, 1'b0);
        wait_drained();

        set_limits(16'd8, 16'd60);
        while (words_sent < 320) begin
            send_text($urandom_range(6, 40), $urandom_range(0, 4) == 0, 1'b0);
            if ($urandom_range(0, 7) == 0) wait_drained();
        end
        wait_drained();

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
